// ===== rtl/gbs_pkg.sv =====
// Shared constants, types and codes for the gyro bias at standstill unit.
package gbs_pkg;

  localparam int MAX_WINDOW  = 512;
  localparam int SAMPLE_BITS = 24;
  localparam int STORE_DEPTH = 2 * MAX_WINDOW;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int FILL_W      = PTR_W + 1;
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int DCNT_W      = $clog2(SUM_W + 1);

  localparam int SPEED_W     = 16;
  localparam int WL_W        = 10;
  localparam int STOP_THR_W  = 15;
  localparam int OUT_THR_W   = 23;
  localparam int CFG_DATA_W  = 23;
  localparam int CFG_IDX_W   = 2;

  localparam logic [WL_W-1:0]       WL_RESET       = WL_W'(400);
  localparam logic [STOP_THR_W-1:0] STOP_THR_RESET = STOP_THR_W'(1);
  localparam logic [OUT_THR_W-1:0]  OUT_THR_RESET  = OUT_THR_W'(2097);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_STOP_SPEED    = 2'd1,
    CFG_OUTLIER       = 2'd2
  } gbs_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_APPEND,
    ST_TRIM,
    ST_CHECK,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } gbs_state_e;

  typedef struct packed {
    logic [WL_W-1:0]       window_length;
    logic [STOP_THR_W-1:0] stop_speed_threshold;
    logic [OUT_THR_W-1:0]  outlier_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0]     speed;
    logic signed [SAMPLE_BITS-1:0] yaw_rate;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] offset;
    logic                          updated;
    logic                          enabled;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [WIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/gbs_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
interface gbs_in_if;
  import gbs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_W-1:0]     speed;
  logic signed [SAMPLE_BITS-1:0] yaw_rate;

  modport source (output valid, output speed, output yaw_rate, input ready);
  modport sink   (input valid, input speed, input yaw_rate, output ready);
endinterface

interface gbs_out_if;
  import gbs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] offset;
  logic                          updated;
  logic                          enabled;

  modport source (output valid, output offset, output updated, output enabled, input ready);
  modport sink   (input valid, input offset, input updated, input enabled, output ready);
endinterface

// ===== rtl/gbs_divider.sv =====
// Bit-serial restoring divider for the unsigned window sum by the window length.
module gbs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbs_pkg::div_req_t req_i,
  output gbs_pkg::div_rsp_t rsp_o
);
  import gbs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [WIN_W-1:0]  div_q, div_d;
  logic [WIN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? WIN_W'(trial - {1'b0, div_q}) : trial[WIN_W-1:0];
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(SUM_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/gbs_core.sv =====
// Sequencer, sample ring store, window accumulator and offset update.
module gbs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbs_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gbs_pkg::sample_t sample_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output gbs_pkg::res_t    res_o
);
  import gbs_pkg::*;

  localparam int CMP_W = SAMPLE_BITS + OUT_THR_W;
  localparam logic [SUM_W-1:0] QMAX =
    {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SUM_W-1:0] QLIM = QMAX + SUM_W'(1);
  localparam logic [SAMPLE_BITS-1:0] OFS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OFS_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  gbs_state_e state_q, state_d;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] stop_q, stop_d;
  logic              started_q, started_d;
  logic [SAMPLE_BITS-1:0] last_q, last_d;
  logic              rd_pend_q, rd_pend_d;

  logic [SPEED_W-1:0]     speed_q, speed_d;
  logic [SAMPLE_BITS-1:0] yaw_q, yaw_d;
  logic [WIN_W-1:0]       n_q, n_d;
  logic [SAMPLE_BITS:0]   diff_q, diff_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic [WIN_W-1:0]       cnt_q, cnt_d;
  logic [WIN_W-1:0]       idx_q, idx_d;
  logic                   neg_q, neg_d;
  logic [SAMPLE_BITS-1:0] ofs_q, ofs_d;
  logic                   upd_q, upd_d;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic                   mem_we, mem_re;
  logic [PTR_W-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] rdata_q;

  logic [FILL_W-1:0]      full;
  logic [WIN_W-1:0]       n_eff;
  logic [SAMPLE_BITS-1:0] mag_yaw, mag_last;
  logic [SAMPLE_BITS:0]   abs_diff;
  logic                   stopped;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gbs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A window length of zero acts as one, and one above the store's half acts as its limit.
  always_comb begin
    if (cfg_i.window_length == '0) begin
      n_eff = WIN_W'(1);
    end else if (int'(cfg_i.window_length) > MAX_WINDOW) begin
      n_eff = WIN_W'(MAX_WINDOW);
    end else begin
      n_eff = WIN_W'(cfg_i.window_length);
    end
  end

  assign full     = FILL_W'({n_q, 1'b0});
  assign mag_yaw  = yaw_q[SAMPLE_BITS-1] ? -yaw_q : yaw_q;
  assign mag_last = last_q[SAMPLE_BITS-1] ? -last_q : last_q;
  assign abs_diff = diff_q[SAMPLE_BITS] ? -diff_q : diff_q;
  assign stopped  = $signed(speed_q) < $signed({1'b0, cfg_i.stop_speed_threshold});

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    stop_d    = stop_q;
    started_d = started_q;
    last_d    = last_q;
    rd_pend_d = 1'b0;
    speed_d   = speed_q;
    yaw_d     = yaw_q;
    n_d       = n_q;
    diff_d    = diff_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    neg_d     = neg_q;
    ofs_d     = ofs_q;
    upd_d     = upd_q;
    mem_we    = 1'b0;
    mem_waddr = head_q + fill_q[PTR_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = head_q + PTR_W'(idx_q);
    div_req.start    = 1'b0;
    div_req.dividend = acc_q[SUM_W-1] ? -acc_q : acc_q;
    div_req.divisor  = n_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          speed_d = sample_i.speed;
          yaw_d   = sample_i.yaw_rate;
          n_d     = n_eff;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d  = {1'b0, mag_last} - {1'b0, mag_yaw};
        state_d = ST_APPEND;
      end
      ST_APPEND: begin
        if (!started_q ||
            (CMP_W'(abs_diff) < CMP_W'(cfg_i.outlier_limit))) begin
          mem_we = 1'b1;
          // A full ring overwrites its oldest entry and moves the head past it.
          if (fill_q[FILL_W-1]) begin
            head_d = head_q + PTR_W'(1);
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
        if (stopped) begin
          stop_d = (stop_q < full + FILL_W'(1)) ? stop_q + FILL_W'(1) : full + FILL_W'(1);
        end else begin
          stop_d = '0;
        end
        state_d = ST_TRIM;
      end
      ST_TRIM: begin
        if (fill_q > full) begin
          head_d = head_q + PTR_W'(1);
          fill_d = fill_q - FILL_W'(1);
        end
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stop_q > full) begin
          cnt_d   = (fill_q < FILL_W'(n_q)) ? WIN_W'(fill_q) : n_q;
          idx_d   = '0;
          acc_d   = '0;
          state_d = ST_SUM;
        end else begin
          ofs_d   = last_q;
          upd_d   = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_SUM: begin
        // Reads are issued one per beat; each datum is added in the next cycle.
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + WIN_W'(1);
        end
        if (rd_pend_q) begin
          acc_d = acc_q + {{(SUM_W-SAMPLE_BITS){rdata_q[SAMPLE_BITS-1]}}, rdata_q};
        end
        if (idx_q == cnt_q && !rd_pend_q) begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        neg_d         = acc_q[SUM_W-1];
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          // The offset is the negated mean, clamped to the sample range.
          if (neg_q) begin
            ofs_d = (div_rsp.quotient > QMAX) ? OFS_MAX
                                              : div_rsp.quotient[SAMPLE_BITS-1:0];
          end else begin
            ofs_d = (div_rsp.quotient > QLIM) ? OFS_MIN
                                              : -div_rsp.quotient[SAMPLE_BITS-1:0];
          end
          last_d    = ofs_d;
          upd_d     = 1'b1;
          started_d = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.offset  = ofs_q;
  assign res_o.updated = upd_q;
  assign res_o.enabled = started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      stop_q    <= '0;
      started_q <= 1'b0;
      last_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      stop_q    <= stop_d;
      started_q <= started_d;
      last_q    <= last_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    yaw_q   <= yaw_d;
    n_q     <= n_d;
    diff_q  <= diff_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    neg_q   <= neg_d;
    ofs_q   <= ofs_d;
    upd_q   <= upd_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= yaw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/gyro_bias_at_standstill_unit.sv =====
// Top level of the gyro bias at standstill unit: registers, output stage, checks.
//
// One beat on sample_i carries a vehicle speed and a yaw-rate sample; each
// sample yields exactly one beat on result_o with the yaw offset estimate,
// an updated flag and an enabled flag. Both channels use valid/ready.
// Three registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i:
// 0 window length N, 1 stop speed threshold, 2 outlier threshold.
// Write them only while no sample is in flight.
// When no estimate is due, an accepted sample passes through the difference,
// append, trim and check steps to its result. When the stop counter calls
// for an estimate, the oldest stored samples, min(fill, N) of them, are
// summed one per cycle through the store's single read port, then a
// bit-serial divider forms the mean. Samples are processed one at a time.
// The result sits in an output register, so a new sample is accepted
// while the previous result still waits; a stalled receiver holds the
// next result inside the block until the register frees.
// Reset restores the register defaults and clears the fill count, stop
// counter and last offset; the sample store needs no clearing.
module gyro_bias_at_standstill_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gbs_in_if.sink                          sample_i,
  gbs_out_if.source                       result_o,
  input  logic                            cfg_we_i,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import gbs_pkg::*;

  cfg_t    cfg_q, cfg_d;
  sample_t sample;
  res_t    res;
  res_t    out_q;
  logic    out_valid_q;
  logic    res_valid, res_ready;
  logic    in_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gbs_cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_LENGTH: cfg_d.window_length        = cfg_wdata_i[WL_W-1:0];
        CFG_STOP_SPEED:    cfg_d.stop_speed_threshold = cfg_wdata_i[STOP_THR_W-1:0];
        CFG_OUTLIER:       cfg_d.outlier_limit        = cfg_wdata_i[OUT_THR_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length        <= WL_RESET;
      cfg_q.stop_speed_threshold <= STOP_THR_RESET;
      cfg_q.outlier_limit        <= OUT_THR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign sample.speed    = sample_i.speed;
  assign sample.yaw_rate = sample_i.yaw_rate;
  assign sample_i.ready  = in_ready;

  gbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.offset  = out_q.offset;
  assign result_o.updated = out_q.updated;
  assign result_o.enabled = out_q.enabled;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && in_ready) |=> !in_ready)
    else $error("sample accepted while a previous one is still being processed");

  a_updated_implies_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.updated) |-> result_o.enabled)
    else $error("fresh estimate reported without the enabled flag");

  a_zero_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.enabled) |-> (result_o.offset == '0))
    else $error("nonzero offset reported before the first estimate");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("result handed over but output register not loaded");

endmodule
